// ===== hw/rtl/mcep_pkg.sv =====
// shared types, codes and constants of the multi-channel esc pulse generator
package mcep_pkg;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int PULSE_W          = 16;
   localparam int THR_W            = 18;
   localparam int CH_W             = 4;
   localparam int LINES_W          = 4;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 16;

   localparam logic [PULSE_W-1:0] RST_MIN_PULSE    = 16'd1000;
   localparam logic [PULSE_W-1:0] RST_MAX_PULSE    = 16'd2000;
   localparam logic [PULSE_W-1:0] RST_SPIN_PULSE   = 16'd1100;
   localparam logic [PULSE_W-1:0] RST_PERIOD_TICKS = 16'd20000;
   localparam logic [16:0]        Q16_ONE          = 17'd65536;

   typedef enum logic [2:0] {
      REQ_TICK     = 3'd0,
      REQ_PULSE    = 3'd1,
      REQ_THROTTLE = 3'd2,
      REQ_ARM      = 3'd3,
      REQ_DISARM   = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOT_ENABLED = 2'd1,
      ST_BAD_CHANNEL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE       = 3'd0,
      CSR_MIN_PULSE    = 3'd1,
      CSR_MAX_PULSE    = 3'd2,
      CSR_SPIN_PULSE   = 3'd3,
      CSR_PERIOD_TICKS = 3'd4
   } csr_index_type;

   typedef struct packed {
      req_kind_type         req_type;
      logic [CH_W-1:0]      channel;
      logic [PULSE_W-1:0]   pulse_width;
      logic [THR_W-1:0]     throttle;
   } req_item_type;

   typedef struct packed {
      logic [LINES_W-1:0] pwm_lines;
      status_type         status;
   } rsp_item_type;

   function automatic logic [PULSE_W-1:0] clamp_width(
      input logic [PULSE_W-1:0] p,
      input logic [PULSE_W-1:0] lo,
      input logic [PULSE_W-1:0] hi
   );
      logic [PULSE_W-1:0] r;
      begin
         if (p < lo) begin
            r = lo;
         end else if (p > hi) begin
            r = hi;
         end else begin
            r = p;
         end
         return r;
      end
   endfunction

endpackage

// ===== hw/rtl/multi_channel_esc_pulse_generator_unit.sv =====
// top level of the multi-channel esc pulse generator
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser: req_type; tdata: channel, pulse_width, throttle
//   rsp      out  rsp_tvalid/tready    tdata: pwm_lines, status
//   csr      in   csr_we               csr_index, csr_wdata
//
// one request per cycle sustained while rsp is not stalled; a result reaches rsp through
// the input register, then the compare update into the result register
// reset loads the register defaults, compares to 1000, counter zero and lines low
// a stalled rsp holds its result; the input register still takes one more request if empty
module multi_channel_esc_pulse_generator_unit
   import mcep_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,  // channel, pulse_width, throttle, zero pad
   input  logic [2:0]            req_tuser,  // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // pwm_lines, status, zero pad
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   req_item_type req_item;
   req_item_type stage_item;
   logic         stage_valid;
   logic         stage_take;
   rsp_item_type core_result;
   rsp_item_type rsp_item;

   always_comb begin
      req_item.req_type    = req_kind_type'(req_tuser);
      req_item.channel     = req_tdata[3:0];
      req_item.pulse_width = req_tdata[19:4];
      req_item.throttle    = req_tdata[37:20];
   end

   mcep_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_take  (stage_take),
      .out_item  (stage_item)
   );

   mcep_core #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .go        (stage_take),
      .item      (stage_item),
      .result    (core_result)
   );

   mcep_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_take   (stage_take),
      .in_item   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {2'b00, rsp_item.status, rsp_item.pwm_lines};

endmodule

// ===== hw/rtl/mcep_in_stage.sv =====
// input register of the request channel
module mcep_in_stage
   import mcep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output req_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== hw/rtl/mcep_core.sv =====
// configuration registers, period counter, compares and line levels
module mcep_core
   import mcep_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  go,
   input  req_item_type          item,
   output rsp_item_type          result
);

   logic                    enable_ff;
   logic [PULSE_W-1:0]      min_ff;
   logic [PULSE_W-1:0]      max_ff;
   logic [PULSE_W-1:0]      spin_ff;
   logic [PULSE_W-1:0]      period_ff;

   logic [PULSE_W-1:0]      count_ff;
   logic [PULSE_W-1:0]      count_in;
   logic [PULSE_W-1:0]      shadow_ff [NUM_CHANNELS];
   logic [PULSE_W-1:0]      shadow_in [NUM_CHANNELS];
   logic [PULSE_W-1:0]      active_ff [NUM_CHANNELS];
   logic [PULSE_W-1:0]      active_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] lines_ff;
   logic [NUM_CHANNELS-1:0] lines_in;

   logic [PULSE_W-1:0]      per;
   logic [PULSE_W:0]        count_inc;
   logic                    wrap;
   logic [PULSE_W-1:0]      span;
   logic [16:0]             thr_clamped;
   logic [32:0]             product;
   logic [PULSE_W:0]        thr_sum;
   logic [PULSE_W-1:0]      thr_width;
   logic                    ch_ok;
   logic                    ch_wr;
   logic [PULSE_W-1:0]      ch_val;
   logic                    all_wr;
   logic [PULSE_W-1:0]      all_val;
   logic                    tick;
   status_type              status;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         min_ff    <= RST_MIN_PULSE;
         max_ff    <= RST_MAX_PULSE;
         spin_ff   <= RST_SPIN_PULSE;
         period_ff <= RST_PERIOD_TICKS;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:       enable_ff <= csr_wdata[0];
            CSR_MIN_PULSE:    min_ff    <= csr_wdata;
            CSR_MAX_PULSE:    max_ff    <= csr_wdata;
            CSR_SPIN_PULSE:   spin_ff   <= csr_wdata;
            CSR_PERIOD_TICKS: period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // throttle scaling
   always_comb begin
      if (item.throttle[THR_W-1]) begin
         thr_clamped = '0;
      end else if (item.throttle[THR_W-2:0] > Q16_ONE) begin
         thr_clamped = Q16_ONE;
      end else begin
         thr_clamped = item.throttle[16:0];
      end
      span      = (max_ff > min_ff) ? (max_ff - min_ff) : '0;
      product   = {16'd0, thr_clamped} * {17'd0, span};
      thr_sum   = {1'b0, min_ff} + product[32:16];
      thr_width = clamp_width(thr_sum[PULSE_W-1:0], min_ff, max_ff);
   end

   // request decode
   always_comb begin
      ch_ok   = {1'b0, item.channel} < (CH_W+1)'(NUM_CHANNELS);
      ch_wr   = 1'b0;
      ch_val  = clamp_width(item.pulse_width, min_ff, max_ff);
      all_wr  = 1'b0;
      all_val = clamp_width(min_ff, min_ff, max_ff);
      tick    = 1'b0;
      status  = ST_OK;
      case (item.req_type)
         REQ_TICK: begin
            if (!enable_ff) status = ST_NOT_ENABLED;
            else            tick   = 1'b1;
         end
         REQ_PULSE, REQ_THROTTLE: begin
            if (!enable_ff) begin
               status = ST_NOT_ENABLED;
            end else if (!ch_ok) begin
               status = ST_BAD_CHANNEL;
            end else begin
               ch_wr = 1'b1;
               if (item.req_type == REQ_THROTTLE) ch_val = thr_width;
            end
         end
         REQ_ARM: begin
            if (!enable_ff) begin
               status = ST_NOT_ENABLED;
            end else begin
               all_wr  = 1'b1;
               all_val = clamp_width(spin_ff, min_ff, max_ff);
            end
         end
         REQ_DISARM: begin
            if (!enable_ff) status = ST_NOT_ENABLED;
            else            all_wr = 1'b1;
         end
         default: ;
      endcase
   end

   // counter, compares and lines
   always_comb begin
      per       = (period_ff == '0) ? PULSE_W'(1) : period_ff;
      count_inc = {1'b0, count_ff} + (PULSE_W+1)'(1);
      wrap      = count_inc >= {1'b0, per};
      count_in  = count_ff;
      lines_in  = lines_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         active_in[i] = active_ff[i];
         if (all_wr || (ch_wr && item.channel == CH_W'(i))) begin
            shadow_in[i] = all_wr ? all_val : ch_val;
         end else begin
            shadow_in[i] = shadow_ff[i];
         end
      end
      if (tick) begin
         count_in = wrap ? '0 : count_inc[PULSE_W-1:0];
         if (wrap) lines_in = '1;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (wrap) active_in[i] = shadow_ff[i];
            if (count_in == active_in[i]) lines_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lines_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            shadow_ff[i] <= RST_MIN_PULSE;
            active_ff[i] <= RST_MIN_PULSE;
         end
      end else if (go) begin
         count_ff <= count_in;
         lines_ff <= lines_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            shadow_ff[i] <= shadow_in[i];
            active_ff[i] <= active_in[i];
         end
      end
   end

   always_comb begin
      result.pwm_lines = '0;
      for (int i = 0; i < LINES_W; i++) begin
         if (i < NUM_CHANNELS) result.pwm_lines[i] = lines_in[i];
      end
      result.status = status;
   end

endmodule

// ===== hw/rtl/mcep_out_stage.sv =====
// result register of the response channel
module mcep_out_stage
   import mcep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_take,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign in_take   = in_valid && (!valid_ff || out_ready);
   assign valid_in  = in_take || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== hw/rtl/mcep_checker.sv =====
// port-level checks of the pulse generator and their binding
module mcep_checker
   import mcep_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   localparam logic [LINES_W-1:0] LINE_MASK =
      (NUM_CHANNELS >= LINES_W) ? {LINES_W{1'b1}} : LINES_W'((1 << NUM_CHANNELS) - 1);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // no result straight after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // status only carries defined codes and the pad bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:4] != 2'd3 && rsp_tdata[7:6] == 2'b00)
      else $error("bad status code");

   // lines of absent channels stay low
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] & ~LINE_MASK) == '0)
      else $error("line of absent channel high");

   // a request transfer leads to a result through the input and result registers when output is free
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after transfer");

endmodule

bind multi_channel_esc_pulse_generator_unit mcep_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_mcep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
